// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
// Holds only macro definitions behind an include guard.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CHK_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Implication checked at every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== sv/rbqs_pkg.sv =====
// Package for the ready/blocked queue scheduler.
// Holds the operation codes, the sequencer states, the default depth and the id and count widths.
package rbqs_pkg;

  localparam int unsigned DefQueueDepth = 16;
  localparam int unsigned IdW = 8;
  localparam int unsigned CountW = 5;

  typedef enum logic [2:0] {
    OP_YIELD     = 3'd0,
    OP_ADD       = 3'd1,
    OP_RESUME    = 3'd2,
    OP_PARK      = 3'd3,
    OP_TERMINATE = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_HEAD,
    ST_DONE
  } state_t;

endpackage

// ===== sv/rbqs_ram.sv =====
// Generic single-port-write, single-port-read memory with registered read data.
// Depends on nothing.
module rbqs_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/ready_blocked_queue_scheduler.sv =====
// Channel | Signals                                         | Direction
// in      | in_valid, in_ready, mode, thread_id              | to block
// out     | out_valid, out_ready, dispatch_valid, dispatch_id,
//         | removed, overflow, ready_count, blocked_count     | from block
// Terminate walks through the ready memory to remove the thread if present,
// then dispatches the head as yield does.
// Both queues are circular buffers in memories with one read port each.
// Reset clears the state, pointers, counts, out_valid and pend. One word is worked on at a
// time; the next is taken once the result register is free.
// Depends on rbqs_pkg and rbqs_ram.
module ready_blocked_queue_scheduler
  import rbqs_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DefQueueDepth
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          mode,
  input  logic [IdW-1:0]      thread_id,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                dispatch_valid,
  output logic [IdW-1:0]      dispatch_id,
  output logic                removed,
  output logic                overflow,
  output logic [CountW-1:0]   ready_count,
  output logic [CountW-1:0]   blocked_count
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned LW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [LW-1:0] FullLen = LW'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LastIdx = AW'(QUEUE_DEPTH - 1);

  state_t state, state_next;
  logic [2:0] op;
  logic [IdW-1:0] tid;
  logic [AW-1:0] r_head, b_head;
  logic [LW-1:0] r_len, b_len;
  logic [LW-1:0] scan_i;
  logic [AW-1:0] hole;
  logic pend;
  logic found;
  logic ovf_acc;

  logic r_we;
  logic [AW-1:0] r_waddr, r_raddr;
  logic [IdW-1:0] r_wdata, r_rdata;
  logic b_we;
  logic [AW-1:0] b_waddr;
  logic [IdW-1:0] b_rdata;

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base, input logic [LW-1:0] off);
    logic [LW:0] s;
    s = (LW+1)'(base) + (LW+1)'(off);
    if (s >= (LW+1)'(QUEUE_DEPTH)) begin
      s = s - (LW+1)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] dec(input logic [AW-1:0] p);
    return (p == '0) ? LastIdx : p - AW'(1);
  endfunction

  rbqs_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(IdW)) u_ready (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(r_raddr), .rdata(r_rdata)
  );

  rbqs_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(IdW)) u_blocked (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(tid),
    .raddr(b_head), .rdata(b_rdata)
  );

  assign in_ready = (state == ST_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Read address: scan and shift walk entries; otherwise the head.
  always_comb begin
    r_raddr = r_head;
    if (state_next == ST_SCAN || state_next == ST_SHIFT) begin
      r_raddr = wrap(r_head, scan_i);
    end
  end

  always_comb begin
    state_next = state;
    r_we = 1'b0;
    r_waddr = wrap(r_head, r_len);
    r_wdata = tid;
    b_we = 1'b0;
    b_waddr = wrap(b_head, b_len);
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          state_next = (mode == OP_TERMINATE) ? ST_SCAN : ST_HEAD;
        end
      end
      ST_SCAN: begin
        if (pend && r_rdata == tid) begin
          state_next = ST_SHIFT;
        end else if (scan_i >= r_len) begin
          state_next = ST_HEAD;
        end
      end
      ST_SHIFT: begin
        if (pend) begin
          r_we = 1'b1;
          r_waddr = hole;
          r_wdata = r_rdata;
        end
        if (scan_i >= r_len) begin
          state_next = ST_HEAD;
        end
      end
      ST_HEAD: begin
        unique case (op)
          OP_ADD: begin
            r_we = (r_len != FullLen);
            state_next = ST_DONE;
          end
          OP_PARK: begin
            b_we = (b_len != FullLen);
            state_next = ST_DONE;
          end
          OP_RESUME: begin
            if (pend) begin
              r_we = (b_len != '0) && (r_len != FullLen);
              r_waddr = dec(r_head);
              r_wdata = b_rdata;
              state_next = ST_DONE;
            end else begin
              r_we = (r_len != FullLen);
            end
          end
          default: begin
            state_next = pend || (op != OP_YIELD && op != OP_TERMINATE) ? ST_DONE : state;
          end
        endcase
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_head <= '0;
      b_head <= '0;
      r_len <= '0;
      b_len <= '0;
      out_valid <= 1'b0;
      pend <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          pend <= 1'b0;
          if (in_valid && in_ready) begin
            op <= mode;
            tid <= thread_id;
            scan_i <= '0;
            found <= 1'b0;
            ovf_acc <= 1'b0;
            dispatch_valid <= 1'b0;
            dispatch_id <= '0;
          end
        end
        ST_SCAN: begin
          if (pend && r_rdata == tid) begin
            found <= 1'b1;
            hole <= wrap(r_head, scan_i - LW'(1));
            pend <= 1'b0;
          end else if (scan_i < r_len) begin
            scan_i <= scan_i + LW'(1);
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
        end
        ST_SHIFT: begin
          if (pend) begin
            hole <= wrap(r_head, scan_i - LW'(1));
          end
          if (scan_i < r_len) begin
            scan_i <= scan_i + LW'(1);
            pend <= 1'b1;
          end else begin
            r_len <= r_len - LW'(1);
            pend <= 1'b0;
          end
        end
        ST_HEAD: begin
          unique case (op)
            OP_ADD: begin
              if (r_len != FullLen) r_len <= r_len + LW'(1);
              else ovf_acc <= 1'b1;
            end
            OP_PARK: begin
              if (b_len != FullLen) b_len <= b_len + LW'(1);
              else ovf_acc <= 1'b1;
            end
            OP_RESUME: begin
              if (!pend) begin
                pend <= 1'b1;
                if (r_len != FullLen) r_len <= r_len + LW'(1);
                else ovf_acc <= 1'b1;
              end else if (b_len != '0) begin
                if (r_len != FullLen) begin
                  r_head <= dec(r_head);
                  r_len <= r_len + LW'(1);
                  b_head <= wrap(b_head, LW'(1));
                  b_len <= b_len - LW'(1);
                end else begin
                  ovf_acc <= 1'b1;
                end
              end
            end
            OP_YIELD, OP_TERMINATE: begin
              if (!pend) begin
                pend <= 1'b1;
              end else if (r_len != '0) begin
                dispatch_valid <= 1'b1;
                dispatch_id <= r_rdata;
                r_head <= wrap(r_head, LW'(1));
                r_len <= r_len - LW'(1);
              end
            end
            default: ;
          endcase
        end
        ST_DONE: begin
          out_valid <= 1'b1;
          removed <= found;
          overflow <= ovf_acc;
          ready_count <= CountW'(r_len);
          blocked_count <= CountW'(b_len);
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/rbqs_checker.sv =====
// Port-level checker for the scheduler, attached by bind.
// Depends on rbqs_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rbqs_checker
  import rbqs_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              dispatch_valid,
  input logic [IdW-1:0]    dispatch_id,
  input logic              removed,
  input logic [CountW-1:0] ready_count
);

  `CHK_IMPLY(a_out_hold, clk, rst, $past(out_valid && !out_ready) && !$past(rst), out_valid, "result word dropped while stalled")
  `CHK_IMPLY(a_no_take_busy, clk, rst, out_valid, !in_ready, "input taken while result pending")
  `CHK_IMPLY(a_zero_id, clk, rst, out_valid && !dispatch_valid, dispatch_id == '0, "nonzero id without dispatch")
  `CHK_IMPLY(a_out_stable, clk, rst, $past(out_valid && !out_ready) && !$past(rst), $stable(dispatch_valid) && $stable(dispatch_id) && $stable(removed) && $stable(ready_count), "result word changed while stalled")

endmodule

bind ready_blocked_queue_scheduler rbqs_checker u_rbqs_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .dispatch_valid(dispatch_valid),
  .dispatch_id(dispatch_id), .removed(removed), .ready_count(ready_count)
);

// ===== sim/ready_blocked_queue_scheduler_tb.sv =====
// Testbench for the ready/blocked queue scheduler: drives random and directed
// events, predicts each result word with a queue model and checks every field.
// Depends on rbqs_pkg and the ready_blocked_queue_scheduler RTL.
module ready_blocked_queue_scheduler_tb;
  import rbqs_pkg::*;

  localparam int Depth = DefQueueDepth;

  typedef struct packed {
    logic             dv;
    logic [IdW-1:0]   did;
    logic             rem;
    logic             ovf;
    logic [CountW-1:0] rcnt;
    logic [CountW-1:0] bcnt;
  } sched_result_t;

  class sched_scoreboard;
    logic [IdW-1:0] ready_q[$];
    logic [IdW-1:0] blocked_q[$];
    sched_result_t pending[$];
    int errors = 0;

    function void note_event(logic [2:0] op, logic [IdW-1:0] id);
      sched_result_t r;
      r = '0;
      case (op)
        OP_YIELD: begin
          if (ready_q.size() > 0) begin
            r.dv = 1'b1;
            r.did = ready_q.pop_front();
          end
        end
        OP_ADD: begin
          if (ready_q.size() < Depth) ready_q.push_back(id);
          else r.ovf = 1'b1;
        end
        OP_RESUME: begin
          if (ready_q.size() < Depth) ready_q.push_back(id);
          else r.ovf = 1'b1;
          if (blocked_q.size() > 0) begin
            if (ready_q.size() < Depth) ready_q.push_front(blocked_q.pop_front());
            else r.ovf = 1'b1;
          end
        end
        OP_PARK: begin
          if (blocked_q.size() < Depth) blocked_q.push_back(id);
          else r.ovf = 1'b1;
        end
        OP_TERMINATE: begin
          foreach (ready_q[i]) begin
            if (ready_q[i] == id) begin
              ready_q.delete(i);
              r.rem = 1'b1;
              break;
            end
          end
          if (ready_q.size() > 0) begin
            r.dv = 1'b1;
            r.did = ready_q.pop_front();
          end
        end
        default: ;
      endcase
      r.rcnt = CountW'(ready_q.size());
      r.bcnt = CountW'(blocked_q.size());
      pending.push_back(r);
    endfunction

    function void check_word(sched_result_t got);
      sched_result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected dv=%0d id=%0d rem=%0d ovf=%0d rc=%0d bc=%0d, got dv=%0d id=%0d rem=%0d ovf=%0d rc=%0d bc=%0d",
                   want.dv, want.did, want.rem, want.ovf, want.rcnt, want.bcnt,
                   got.dv, got.did, got.rem, got.ovf, got.rcnt, got.bcnt);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] mode = '0;
  logic [IdW-1:0] thread_id = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic dispatch_valid;
  logic [IdW-1:0] dispatch_id;
  logic removed;
  logic overflow;
  logic [CountW-1:0] ready_count;
  logic [CountW-1:0] blocked_count;

  sched_scoreboard sb = new();
  int cycle_count = 0;
  bit quiet = 0;

  ready_blocked_queue_scheduler uut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (quiet || p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid && out_ready)
      sb.check_word({dispatch_valid, dispatch_id, removed, overflow,
                     ready_count, blocked_count});
    if (!rst && in_valid && in_ready) sb.note_event(mode, thread_id);
    if (cycle_count > 400000) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int g;
    @(negedge clk);
    while (1) begin
      g = pick_gap();
      out_ready <= (g == 0);
      repeat (g > 0 ? g : 1) @(negedge clk);
      out_ready <= 1'b1;
      @(negedge clk);
    end
  end

  task automatic send_event(logic [2:0] op, logic [IdW-1:0] id);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= op;
    thread_id <= id;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [2:0] rand_op();
    int p;
    p = $urandom_range(0, 99);
    if (p < 20) return OP_YIELD;
    if (p < 45) return OP_ADD;
    if (p < 60) return OP_RESUME;
    if (p < 75) return OP_PARK;
    if (p < 96) return OP_TERMINATE;
    return 3'($urandom_range(5, 7));
  endfunction

  initial begin
    logic [IdW-1:0] id;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    send_event(OP_YIELD, 8'hff);
    send_event(OP_TERMINATE, 8'h00);
    send_event(OP_RESUME, 8'h00);
    send_event(OP_PARK, 8'hff);
    send_event(OP_PARK, 8'h55);
    for (int i = 0; i < 17; i++) send_event(OP_ADD, 8'(i * 15));
    send_event(OP_RESUME, 8'haa);
    send_event(OP_TERMINATE, 8'h3c);
    send_event(OP_TERMINATE, 8'h07);
    send_event(3'd5, 8'h12);
    send_event(3'd7, 8'h34);
    for (int i = 0; i < 900; i++) begin
      if (i == 300) quiet = 1;
      if (i == 360) quiet = 0;
      if ($urandom_range(0, 1) && sb.ready_q.size() > 0)
        id = sb.ready_q[$urandom_range(0, sb.ready_q.size() - 1)];
      else
        id = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
      send_event(rand_op(), id);
    end
    in_valid <= 1'b0;
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/rbqs_pkg.sv
sv/rbqs_ram.sv
sv/ready_blocked_queue_scheduler.sv
sv/rbqs_checker.sv
sim/ready_blocked_queue_scheduler_tb.sv
